### hdl/gidf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gidf_pkg;

  // Item kinds carried on the mode field.
  typedef enum logic [1:0] {
    MODE_EVENT  = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_PERIOD = 2'd2
  } mode_t;

  // Event code bits.
  localparam logic [3:0] EV_LEVEL_LOW  = 4'h1;
  localparam logic [3:0] EV_LEVEL_HIGH = 4'h2;
  localparam logic [3:0] EV_RISE       = 4'h4;
  localparam logic [3:0] EV_FALL       = 4'h8;
  localparam logic [3:0] EV_BOTH_EDGES = 4'hc;
  localparam logic [3:0] EV_NONE       = 4'h0;

  // Edge selections on arming.
  localparam logic [2:0] EDGE_FALL       = 3'd0;
  localparam logic [2:0] EDGE_RISE       = 3'd1;
  localparam logic [2:0] EDGE_BOTH       = 3'd2;
  localparam logic [2:0] EDGE_LEVEL_HIGH = 3'd3;
  localparam logic [2:0] EDGE_LEVEL_LOW  = 3'd4;

  localparam int unsigned US_PER_MS = 1000;

  // One table entry per pin.
  typedef struct packed {
    logic        armed;
    logic [3:0]  event_mask;
    logic [31:0] period_us;
    logic [31:0] start_us;
    logic        active;
  } entry_t;

  // The item as held for the read-modify-write cycle.
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  event_code;
    logic        pin_level;
    logic [31:0] now_us;
    logic [2:0]  edge_kind;
    logic [31:0] period_us;
  } op_t;

  function automatic logic [3:0] edge_to_mask(input logic [2:0] kind);
    logic [3:0] m;
    case (kind)
      EDGE_FALL:       m = EV_FALL;
      EDGE_RISE:       m = EV_RISE;
      EDGE_BOTH:       m = EV_BOTH_EDGES;
      EDGE_LEVEL_HIGH: m = EV_LEVEL_HIGH;
      EDGE_LEVEL_LOW:  m = EV_LEVEL_LOW;
      default:         m = EV_NONE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### hdl/gidf_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Computes the new table entry, the optional report and the reported pin state for one item.
module gidf_update (
  input  var gidf_pkg::entry_t cur,
  input  var gidf_pkg::op_t    op,
  output gidf_pkg::entry_t     nxt,
  output logic                 we,
  output logic                 report,
  output logic                 state
);

  logic [3:0]  masked;
  logic [31:0] elapsed;
  logic        expired;

  assign masked  = op.event_code & cur.event_mask;
  assign elapsed = op.now_us - cur.start_us;
  assign expired = elapsed > cur.period_us;

  always_comb begin
    nxt    = cur;
    we     = 1'b0;
    report = 1'b0;
    unique case (op.mode)
      gidf_pkg::MODE_ARM: begin
        nxt.armed      = 1'b1;
        nxt.event_mask = gidf_pkg::edge_to_mask(op.edge_kind);
        nxt.period_us  = op.period_us;
        we             = 1'b1;
      end
      gidf_pkg::MODE_PERIOD: begin
        nxt.period_us = op.period_us;
        we            = 1'b1;
      end
      gidf_pkg::MODE_EVENT: begin
        // An event still inside its lockout window is dropped outright.
        if ((masked != gidf_pkg::EV_NONE) && !(cur.active && !expired)) begin
          nxt.active = 1'b0;
          we         = 1'b1;
          if (cur.armed) begin
            nxt.start_us = op.now_us;
            nxt.active   = 1'b1;
            report       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A single event bit fixes the state; a combination, or no bit at all, falls back on the level.
  always_comb begin
    case (masked) inside
      gidf_pkg::EV_LEVEL_LOW, gidf_pkg::EV_FALL:  state = 1'b0;
      gidf_pkg::EV_LEVEL_HIGH, gidf_pkg::EV_RISE: state = 1'b1;
      default:                                    state = op.pin_level;
    endcase
  end

endmodule

`default_nettype wire

### hdl/gpio_interrupt_debounce_filter_core.sv
// An item is registered with its pin entry when accepted; the result is registered at write-back.
// A new item is accepted only after the single read-modify-write pass over the pin table ends.
// busy is high only during the write-back cycle; the result strobe overlaps the next idle cycle.
// Reset (rst, synchronous) clears the per-pin valid bits, so every pin reads as unarmed with the
// default period; the table itself is not swept and no clearing cycles are needed.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module gpio_interrupt_debounce_filter_core #(
  parameter int unsigned PIN_COUNT         = 30,
  parameter int unsigned DEFAULT_PERIOD_US = 10000
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire [1:0]  mode,
  input  wire [4:0]  pin,
  input  wire [3:0]  event_code,
  input  wire        pin_level,
  input  wire [31:0] now_us,
  input  wire [2:0]  edge_kind,
  input  wire [15:0] period_ms,
  output logic       done,
  output logic [4:0] out_pin,
  output logic       pin_state
);

  localparam int unsigned IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // The pin table lives in one synchronous memory. Entries that have never been
  // written since reset are masked by a valid bit and read as the reset entry.
  gidf_pkg::entry_t mem [PIN_COUNT];
  logic [PIN_COUNT-1:0] valid_bits;

  gidf_pkg::entry_t rdata;
  logic             rvalid;
  gidf_pkg::entry_t cur;
  gidf_pkg::entry_t nxt;
  gidf_pkg::entry_t reset_entry;

  gidf_pkg::op_t    op;
  logic [IDX_W-1:0] idx;
  logic             in_range;

  logic accept;
  logic rmw;          // the cycle in which the read data is valid
  logic we;
  logic report;
  logic state;

  logic [25:0] period_prod;
  logic [31:0] period_new;

  assign accept = start && !busy;
  assign busy   = rmw;

  // Scale milliseconds to microseconds; zero on arming picks the default.
  assign period_prod = 26'(period_ms) * 26'(gidf_pkg::US_PER_MS);
  always_comb begin
    if ((mode == gidf_pkg::MODE_ARM) && (period_ms == 16'd0)) begin
      period_new = 32'(DEFAULT_PERIOD_US);
    end else begin
      period_new = 32'(period_prod);
    end
  end

  // Capture the item and read its table entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      op.mode       <= mode;
      op.event_code <= event_code;
      op.pin_level  <= pin_level;
      op.now_us     <= now_us;
      op.edge_kind  <= edge_kind;
      op.period_us  <= period_new;
      idx           <= pin[IDX_W-1:0];
      in_range      <= (6'(pin) < 6'(PIN_COUNT));
      rdata         <= mem[pin[IDX_W-1:0]];
      rvalid        <= valid_bits[pin[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmw <= 1'b0;
    end else begin
      rmw <= accept;
    end
  end

  always_comb begin
    reset_entry            = '0;
    reset_entry.period_us  = 32'(DEFAULT_PERIOD_US);
    cur = rvalid ? rdata : reset_entry;
  end

  gidf_update u_update (
    .cur    (cur),
    .op     (op),
    .nxt    (nxt),
    .we     (we),
    .report (report),
    .state  (state)
  );

  // Write-back. Out-of-range pins leave the table untouched.
  always_ff @(posedge clk) begin
    if (rmw && in_range && we) begin
      mem[idx] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (rmw && in_range && we) begin
      valid_bits[idx] <= 1'b1;
    end
  end

  // Result register: one cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rmw && in_range && report;
    end
  end

  always_ff @(posedge clk) begin
    if (rmw) begin
      out_pin   <= 5'(idx);
      pin_state <= state;
    end
  end

  // A result only follows a write-back cycle.
  a_done_after_rmw: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rmw))
    else $error("result strobe without a preceding write-back cycle");

  // An accepted item is always followed by its write-back, with busy high and then low again.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy ##1 !busy))
    else $error("accepted item did not take a single write-back cycle");

  // A reported pin is always within the table.
  a_pin_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (6'(out_pin) < 6'(PIN_COUNT)))
    else $error("result reported for a pin outside the table");

  // A result always leaves that pin's entry valid; the assertion checks only the valid bit.
  a_lockout_set: assert property (@(posedge clk) disable iff (rst)
    done |-> valid_bits[out_pin[IDX_W-1:0]])
    else $error("reported pin has no valid table entry");

endmodule

`default_nettype wire
